### hdl/lz77_lazy_phrase_extractor_macros.svh
// assertion helpers for the phrase extractor
`ifndef LZ77_LAZY_PHRASE_EXTRACTOR_MACROS_SVH
`define LZ77_LAZY_PHRASE_EXTRACTOR_MACROS_SVH
`define LZX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LZX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/lzx_pkg.sv
package lzx_pkg;
    localparam int unsigned C_BUF_DEPTH = 65536;
    localparam int unsigned C_POS_W     = 17;
    localparam logic [15:0] C_WIN_RESET = 16'd32768;

    localparam logic C_KIND_LOAD    = 1'b0;
    localparam logic C_KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [16:0] phrase_start;
        logic [16:0] phrase_length;
        logic        done_res;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_LOAD_WR,
        S_CLEAR,
        S_P_INIT,
        S_Q_INIT,
        S_Q_LOAD,
        S_P_TEST,
        S_CMP_A,
        S_CMP_B,
        S_CMP_C,
        S_P_EVAL,
        S_P_NEXT,
        S_Q1_TEST,
        S_Q2_TEST,
        S_CMP2_A,
        S_CMP2_B,
        S_CMP2_C,
        S_Q_EVAL,
        S_Q_NEXT,
        S_DECIDE,
        S_OUT
    } t_state;
endpackage

### hdl/lzx_mem.sv
// single-port synchronous memory with registered read data
module lzx_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/lz77_lazy_phrase_extractor.sv
// channel | dir | handshake          | payload
// in      | in  | i_valid / o_ready  | i_in  (kind, data_byte)
// out     | out | o_valid / i_ready  | o_out (found, start, length, done)
// cfg     | in  | i_cfg_we           | i_cfg_wdata (window size)
// a load passes through S_LOAD and S_LOAD_WR before its result; a request on a finished parse goes straight to S_OUT
// a phrase request sets up in S_P_INIT, S_Q_INIT and S_Q_LOAD, walks the match chains comparing byte
// pairs in the A, B and C compare states (each pair after a bound check in the A state), then decides
// after reset a clearing pass zeroes all 256 entries of the last-seen table with o_ready low
// one item is in flight at a time; a held result keeps o_ready low until it is taken
module lz77_lazy_phrase_extractor #(
    parameter int unsigned BUF_DEPTH = lzx_pkg::C_BUF_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lzx_pkg::t_in_item i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output lzx_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata
);
    import lzx_pkg::*;
    `include "lz77_lazy_phrase_extractor_macros.svh"

    localparam int unsigned MDEPTH = BUF_DEPTH + 1;
    localparam int unsigned AW = $clog2(MDEPTH);
    localparam int unsigned PW = C_POS_W + 1;
    localparam logic [PW-1:0] BUF_LIM = PW'(BUF_DEPTH);

    t_state r_state, n_state;
    logic [15:0]   r_win;
    logic [PW-1:0] r_len, r_pos, r_i, r_p, r_q, r_m, r_ql, r_best, r_n;
    logic [PW-1:0] n_len, n_pos, n_i, n_p, n_q, n_m, n_ql, n_best, n_n;
    logic [7:0]    r_clr, n_clr;
    logic [7:0]    r_byte_a, n_byte_a;
    logic          r_outer, n_outer;  // nested walk vs final walk
    t_in_item      r_in;
    t_out_item     r_out, n_out;

    // memory ports
    logic          txt_we, lnk_we, lst_we;
    logic [AW-1:0] txt_addr, lnk_addr;
    logic [7:0]    lst_addr;
    logic [7:0]    txt_wdata, txt_rdata;
    logic [C_POS_W-1:0] lnk_wdata, lnk_rdata, lst_wdata, lst_rdata;

    lzx_mem #(.DEPTH(MDEPTH), .AW(AW), .DW(8)) u_text (
        .i_clk(i_clk), .i_we(txt_we), .i_addr(txt_addr),
        .i_wdata(txt_wdata), .o_rdata(txt_rdata)
    );
    lzx_mem #(.DEPTH(MDEPTH), .AW(AW), .DW(C_POS_W)) u_link (
        .i_clk(i_clk), .i_we(lnk_we), .i_addr(lnk_addr),
        .i_wdata(lnk_wdata), .o_rdata(lnk_rdata)
    );
    lzx_mem #(.DEPTH(256), .AW(8), .DW(C_POS_W)) u_last (
        .i_clk(i_clk), .i_we(lst_we), .i_addr(lst_addr),
        .i_wdata(lst_wdata), .o_rdata(lst_rdata)
    );

    // shared compare operands
    logic          cmp_p;
    logic [PW-1:0] a_base, b_base, a_idx, b_idx;
    logic          cmp_ok;

    always_comb begin
        cmp_p  = (r_state == S_CMP_A) || (r_state == S_CMP_B) || (r_state == S_CMP_C);
        a_base = cmp_p ? r_i : r_i + PW'(1);
        b_base = cmp_p ? r_p : r_q;
        a_idx  = a_base + r_n;
        b_idx  = b_base + r_n;
        cmp_ok = (a_idx <= r_len) && (b_idx <= r_len) && (a_base != b_idx);
    end

    // a nonzero candidate x lies in window when x + win > i
    logic p_in_win, q_in_win;
    assign p_in_win = (r_p != '0) && (({1'b0, r_p} + (PW+1)'(r_win)) > {1'b0, r_i});
    assign q_in_win = (r_q != '0) && (({1'b0, r_q} + (PW+1)'(r_win)) > {1'b0, r_i});

    always_comb begin
        n_state = r_state;
        n_len = r_len; n_pos = r_pos; n_i = r_i; n_p = r_p; n_q = r_q;
        n_m = r_m; n_ql = r_ql; n_best = r_best; n_n = r_n; n_clr = r_clr;
        n_byte_a = r_byte_a; n_outer = r_outer; n_out = r_out;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 8'd1;
                if (r_clr == 8'hFF) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_in.kind == C_KIND_LOAD) begin
                        n_state = S_LOAD;
                    end else if (r_pos < r_len) begin
                        n_i = r_pos; n_m = PW'(1); n_ql = PW'(1); n_best = '0;
                        n_state = S_P_INIT;
                    end else begin
                        n_out = '{found: 1'b0, phrase_start: '0, phrase_length: '0,
                                  done_res: 1'b1};
                        n_state = S_OUT;
                    end
                end
            end
            S_LOAD: n_state = S_LOAD_WR;  // last-seen entry being read
            S_LOAD_WR: begin
                if (r_len < BUF_LIM) n_len = r_len + PW'(1);
                n_out = '{found: 1'b0, phrase_start: '0, phrase_length: '0,
                          done_res: (r_pos >= n_len)};
                n_state = S_OUT;
            end
            S_P_INIT: n_state = S_Q_INIT;  // link(i) reading
            S_Q_INIT: begin
                n_p = PW'(lnk_rdata);
                n_state = S_Q_LOAD;
            end
            S_Q_LOAD: begin
                n_q = PW'(lnk_rdata);
                n_state = S_P_TEST;
            end
            S_P_TEST: begin
                if (p_in_win) begin
                    n_n = PW'(1);
                    n_state = S_CMP_A;
                end else begin
                    n_outer = 1'b0;
                    n_state = (r_m > PW'(1)) ? S_Q2_TEST : S_DECIDE;
                end
            end
            S_CMP_A: begin
                if (cmp_ok) n_state = S_CMP_B;
                else n_state = S_P_EVAL;
            end
            S_CMP_B: begin
                n_byte_a = txt_rdata;
                n_state = S_CMP_C;
            end
            S_CMP_C: begin
                if (r_byte_a == txt_rdata) begin
                    n_n = r_n + PW'(1);
                    n_state = S_CMP_A;
                end else begin
                    n_state = S_P_EVAL;
                end
            end
            S_P_EVAL: begin
                if (r_n > r_m) begin
                    n_m = r_n;
                    n_best = r_p;
                end
                if (r_n > PW'(2)) begin
                    n_outer = 1'b1;
                    n_state = S_Q1_TEST;
                end else begin
                    n_state = S_P_NEXT;
                end
            end
            S_P_NEXT: begin
                n_p = PW'(lnk_rdata);
                n_state = S_P_TEST;
            end
            S_Q1_TEST: begin
                if (r_q > r_best + PW'(1)) begin
                    n_n = PW'(1);
                    n_state = S_CMP2_A;
                end else begin
                    n_state = S_P_NEXT;
                end
            end
            S_Q2_TEST: begin
                if (q_in_win) begin
                    n_n = PW'(1);
                    n_state = S_CMP2_A;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_CMP2_A: begin
                if (cmp_ok) n_state = S_CMP2_B;
                else n_state = S_Q_EVAL;
            end
            S_CMP2_B: begin
                n_byte_a = txt_rdata;
                n_state = S_CMP2_C;
            end
            S_CMP2_C: begin
                if (r_byte_a == txt_rdata) begin
                    n_n = r_n + PW'(1);
                    n_state = S_CMP2_A;
                end else begin
                    n_state = S_Q_EVAL;
                end
            end
            S_Q_EVAL: begin
                if (r_n > r_ql) n_ql = r_n;
                n_state = S_Q_NEXT;
            end
            S_Q_NEXT: begin
                n_q = PW'(lnk_rdata);
                n_state = r_outer ? S_Q1_TEST : S_Q2_TEST;
            end
            S_DECIDE: begin
                n_out.found = 1'b0;
                n_out.phrase_start = '0;
                n_out.phrase_length = '0;
                if (r_ql < r_m + PW'(1)) begin
                    if (r_m > PW'(2)) begin
                        n_out.found = 1'b1;
                        n_out.phrase_start = C_POS_W'(r_i);
                        n_out.phrase_length = C_POS_W'(r_m);
                        n_pos = r_i + r_m;
                    end else begin
                        n_pos = r_i + PW'(1);
                    end
                end else if (r_ql > PW'(2)) begin
                    n_out.found = 1'b1;
                    n_out.phrase_start = C_POS_W'(r_i + PW'(1));
                    n_out.phrase_length = C_POS_W'(r_ql);
                    n_pos = r_i + r_ql + PW'(1);
                end else begin
                    n_pos = r_i + PW'(1);
                end
                n_out.done_res = (n_pos >= r_len);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory addressing per state; link(p) is read by default so it is ready in S_P_NEXT
    always_comb begin
        txt_we = 1'b0; lnk_we = 1'b0; lst_we = 1'b0;
        txt_addr = AW'(a_idx); lnk_addr = AW'(r_p); lst_addr = r_in.data_byte;
        txt_wdata = r_in.data_byte;
        lnk_wdata = lst_rdata;
        lst_wdata = C_POS_W'(r_len + PW'(1));
        case (r_state)
            S_CLEAR: begin
                lst_we = 1'b1; lst_addr = r_clr; lst_wdata = '0;
            end
            S_LOAD_WR: begin
                txt_we = (r_len < BUF_LIM);
                lnk_we = (r_len < BUF_LIM);
                lst_we = (r_len < BUF_LIM);
                txt_addr = AW'(r_len + PW'(1));
                lnk_addr = AW'(r_len + PW'(1));
            end
            S_P_INIT: lnk_addr = AW'(r_i);
            S_Q_INIT: lnk_addr = AW'(r_i + PW'(1));
            S_CMP_B, S_CMP2_B: txt_addr = AW'(b_idx);
            S_Q_EVAL: lnk_addr = AW'(r_q);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_win <= C_WIN_RESET;
            r_len <= '0; r_pos <= PW'(1); r_clr <= '0;
        end else begin
            r_state <= n_state;
            r_len <= n_len; r_pos <= n_pos; r_clr <= n_clr;
            if (i_cfg_we) r_win <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_p <= n_p; r_q <= n_q; r_m <= n_m; r_ql <= n_ql; r_best <= n_best;
        r_n <= n_n; r_out <= n_out; r_byte_a <= n_byte_a; r_outer <= n_outer;
        if (r_state == S_IDLE && i_valid) r_in <= i_in;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_out   = r_out;

    `LZX_ASSERT_IMP(a_excl, i_clk, i_rst_n, 1'b1, !(o_ready && o_valid))
    `LZX_ASSERT_IMP(a_pos, i_clk, i_rst_n, r_state == S_IDLE, r_pos != '0)
    `LZX_ASSERT_IMP(a_len, i_clk, i_rst_n, 1'b1, r_len <= BUF_LIM)
    `LZX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out))
endmodule
